@@ src/mmc3_mc_pkg.sv @@
// Shared types and constants for the multicart MMC3 bank mapper.
package mmc3_mc_pkg;

  // Bank select codes written to the low bits of an even 8000-9FFF write
  localparam logic [2:0] SEL_CHR_2K_LO = 3'd0;
  localparam logic [2:0] SEL_CHR_2K_HI = 3'd1;
  localparam logic [2:0] SEL_CHR_1K_0  = 3'd2;
  localparam logic [2:0] SEL_CHR_1K_1  = 3'd3;
  localparam logic [2:0] SEL_CHR_1K_2  = 3'd4;
  localparam logic [2:0] SEL_CHR_1K_3  = 3'd5;
  localparam logic [2:0] SEL_PRG_SWAP  = 3'd6;
  localparam logic [2:0] SEL_PRG_MID   = 3'd7;

  // Configuration register indexes
  localparam logic REG_PRG_LAST = 1'b0;
  localparam logic REG_CHR_LAST = 1'b1;

  // Reset values
  localparam logic [5:0] PRG_LAST_RST  = 6'd63;
  localparam logic [8:0] CHR_LAST_RST  = 9'd511;
  localparam logic [5:0] OUTER_RST     = 6'd1;
  localparam logic [7:0] PRG_SLOT0_RST = 8'd0;
  localparam logic [7:0] PRG_SLOT1_RST = 8'd1;
  localparam logic [7:0] PRG_SLOT2_RST = 8'd62;
  localparam logic [7:0] PRG_SLOT3_RST = 8'd63;

  // PRG inner masks, chosen by outer register bit 5
  localparam logic [5:0] PRG_MASK_SMALL = 6'h0F;
  localparam logic [5:0] PRG_MASK_LARGE = 6'h1F;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_OUTER,
    WR_SELECT,
    WR_DATA
  } wr_kind_t;

  typedef struct packed {
    logic [5:0] prg_last;
    logic [8:0] chr_last;
  } rom_size_t;

  typedef struct packed {
    logic [5:0]      outer;
    logic [2:0]      sel;
    logic            prg_mode;
    logic            chr_mode;
    logic [3:0][7:0] prg_val;
    logic [7:0][8:0] chr_val;
  } bank_state_t;

  typedef struct packed {
    logic [7:0][8:0] chr_bank;
    logic [3:0][5:0] prg_bank;
  } bank_out_t;

endpackage

@@ src/mmc3_mc_cfg.sv @@
// APB register file holding the PRG and CHR ROM size registers.
module mmc3_mc_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready,
  output mmc3_mc_pkg::rom_size_t size
);

  logic       wr_en;
  logic [5:0] prg_last_r;
  logic [8:0] chr_last_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_last_r <= mmc3_mc_pkg::PRG_LAST_RST;
      chr_last_r <= mmc3_mc_pkg::CHR_LAST_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == mmc3_mc_pkg::REG_PRG_LAST) begin
        prg_last_r <= cfg_pwdata[5:0];
      end else begin
        chr_last_r <= cfg_pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == mmc3_mc_pkg::REG_CHR_LAST) begin
      cfg_prdata = {23'd0, chr_last_r};
    end else begin
      cfg_prdata = {26'd0, prg_last_r};
    end
  end

  assign size.prg_last = prg_last_r;
  assign size.chr_last = chr_last_r;

endmodule

@@ src/mmc3_mc_state.sv @@
// Mapper register state: CPU write decode, mode swaps and slot loads.
module mmc3_mc_state (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     upd,
  input  logic [15:0]              cpu_address,
  input  logic [7:0]               cpu_data,
  input  mmc3_mc_pkg::rom_size_t   size,
  output mmc3_mc_pkg::bank_state_t state_nxt
);

  mmc3_mc_pkg::bank_state_t state_r;
  mmc3_mc_pkg::bank_state_t st;
  mmc3_mc_pkg::wr_kind_t    kind;
  logic [7:0]               last_m1;
  logic [8:0]               even_val;
  logic [8:0]               odd_val;
  logic [2:0]               sel_m2;

  // 6000-7FFF outer; 8000-9FFF decoded through the E001 mask
  always_comb begin
    if (cpu_address[15:13] == 3'b100 && !cpu_address[0]) begin
      kind = mmc3_mc_pkg::WR_SELECT;
    end else if (cpu_address[15:13] == 3'b100) begin
      kind = mmc3_mc_pkg::WR_DATA;
    end else if (cpu_address[15:13] == 3'b011) begin
      kind = mmc3_mc_pkg::WR_OUTER;
    end else begin
      kind = mmc3_mc_pkg::WR_NONE;
    end
  end

  assign last_m1  = {2'b00, size.prg_last} - 8'd1;  // wraps to FF when size is zero
  assign even_val = {1'b0, cpu_data[7:1], 1'b0};
  assign odd_val  = {1'b0, cpu_data[7:1], 1'b1};
  assign sel_m2   = state_r.sel - 3'd2;

  always_comb begin
    st = state_r;
    if (upd) begin
      case (kind)
        mmc3_mc_pkg::WR_OUTER: begin
          st.outer = {cpu_data[1:0], 4'b0000};
        end
        mmc3_mc_pkg::WR_SELECT: begin
          st.sel      = cpu_data[2:0];
          st.prg_mode = cpu_data[6];
          st.chr_mode = cpu_data[7];
          if (cpu_data[7] != state_r.chr_mode) begin
            for (int k = 0; k < 8; k++) begin
              st.chr_val[k] = state_r.chr_val[k ^ 4];
            end
          end
          if (cpu_data[6] != state_r.prg_mode) begin
            if (cpu_data[6]) begin
              st.prg_val[0] = last_m1;
              st.prg_val[2] = state_r.prg_val[0];
            end else begin
              st.prg_val[0] = state_r.prg_val[2];
              st.prg_val[2] = last_m1;
            end
          end
        end
        mmc3_mc_pkg::WR_DATA: begin
          case (state_r.sel)
            mmc3_mc_pkg::SEL_CHR_2K_LO: begin
              st.chr_val[{state_r.chr_mode, 2'b00}] = even_val;
              st.chr_val[{state_r.chr_mode, 2'b01}] = odd_val;
            end
            mmc3_mc_pkg::SEL_CHR_2K_HI: begin
              st.chr_val[{state_r.chr_mode, 2'b10}] = even_val;
              st.chr_val[{state_r.chr_mode, 2'b11}] = odd_val;
            end
            mmc3_mc_pkg::SEL_CHR_1K_0, mmc3_mc_pkg::SEL_CHR_1K_1,
            mmc3_mc_pkg::SEL_CHR_1K_2, mmc3_mc_pkg::SEL_CHR_1K_3: begin
              st.chr_val[{~state_r.chr_mode, sel_m2[1:0]}] = {1'b0, cpu_data};
            end
            mmc3_mc_pkg::SEL_PRG_SWAP: begin
              st.prg_val[{state_r.prg_mode, 1'b0}] = cpu_data;
            end
            default: begin
              st.prg_val[1] = cpu_data;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign state_nxt = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.outer      <= mmc3_mc_pkg::OUTER_RST;
      state_r.sel        <= mmc3_mc_pkg::SEL_CHR_2K_LO;
      state_r.prg_mode   <= 1'b0;
      state_r.chr_mode   <= 1'b0;
      state_r.prg_val[0] <= mmc3_mc_pkg::PRG_SLOT0_RST;
      state_r.prg_val[1] <= mmc3_mc_pkg::PRG_SLOT1_RST;
      state_r.prg_val[2] <= mmc3_mc_pkg::PRG_SLOT2_RST;
      state_r.prg_val[3] <= mmc3_mc_pkg::PRG_SLOT3_RST;
      for (int k = 0; k < 8; k++) begin
        state_r.chr_val[k] <= 9'(k);
      end
    end else begin
      state_r <= st;
    end
  end

endmodule

@@ src/mmc3_mc_bank.sv @@
// Final bank numbers: outer register merge and ROM size wrap.
module mmc3_mc_bank (
  input  mmc3_mc_pkg::bank_state_t state,
  input  mmc3_mc_pkg::rom_size_t   size,
  output mmc3_mc_pkg::bank_out_t   banks
);

  logic [5:0] prg_mask;
  logic [3:0][5:0] prg_raw;
  logic [7:0][8:0] chr_raw;

  assign prg_mask = state.outer[5] ? mmc3_mc_pkg::PRG_MASK_SMALL
                                   : mmc3_mc_pkg::PRG_MASK_LARGE;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prg_raw[i] = state.outer | (state.prg_val[i][5:0] & prg_mask);
      banks.prg_bank[i] = (prg_raw[i] > size.prg_last) ? (prg_raw[i] & size.prg_last)
                                                        : prg_raw[i];
    end
    for (int i = 0; i < 8; i++) begin
      chr_raw[i] = {state.outer, 3'b000} | state.chr_val[i];
      banks.chr_bank[i] = (chr_raw[i] > size.chr_last) ? (chr_raw[i] & size.chr_last)
                                                        : chr_raw[i];
    end
  end

endmodule

@@ src/multicart_mmc3_bank_mapper_top.sv @@
// Top level of the multicart MMC3 bank mapper: request pipeline and result register.
//
// Each request is one CPU write (address, data). Writes at 6000-7FFF load the
// outer game register, even 8000-9FFF writes (E001 decode) set bank select and
// the PRG/CHR modes, odd ones load the selected slot. Every request yields one
// result with all twelve bank numbers as they stand after that write. One
// request is taken per clock while output back-pressure does not hold the
// pipeline; its result passes from the input register through the slot update
// and bank wrap logic into the result register, which drives the outputs.
// The critical path runs from the input register through the slot update mux
// into the out-of-range compare and mask. Output back-pressure stalls both
// stages together, and a new request is still taken while a result waits as
// long as the input register is free. ROM size registers sit on the APB port
// at 0x0 (PRG last 8K bank) and 0x4 (CHR last 1K bank); write them only while
// no request is in flight.
module multicart_mmc3_bank_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  // APB configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // CPU write requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] cpu_address, [23:16] cpu_data
  // Bank results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // [5:0] prg_bank_slot0, [11:6] prg_bank_slot1,
                                  // [17:12] prg_bank_slot2, [23:18] prg_bank_slot3,
                                  // [32:24] chr_bank_slot0 .. [95:87] chr_bank_slot7,
                                  // 9 bits each
);

  mmc3_mc_pkg::rom_size_t   size;
  mmc3_mc_pkg::bank_state_t state_nxt;
  mmc3_mc_pkg::bank_out_t   banks;
  mmc3_mc_pkg::bank_out_t   out_bank_r;

  logic        in_valid_r;
  logic [15:0] in_addr_r;
  logic [7:0]  in_data_r;
  logic        out_valid_r;
  logic        advance;
  logic        upd;

  // pipeline moves whenever the result register is empty or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign upd       = in_valid_r && advance;

  mmc3_mc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .size        (size)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_addr_r <= in_tdata[15:0];
      in_data_r <= in_tdata[23:16];
    end
  end

  // state is updated as the request leaves the input register
  mmc3_mc_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (upd),
    .cpu_address (in_addr_r),
    .cpu_data    (in_data_r),
    .size        (size),
    .state_nxt   (state_nxt)
  );

  mmc3_mc_bank u_bank (
    .state (state_nxt),
    .size  (size),
    .banks (banks)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_bank_r <= banks;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bank_r.chr_bank, out_bank_r.prg_bank};

endmodule

@@ src/mmc3_mc_checker.sv @@
// Port-level checks for the bank mapper, bound to the top level.
module mmc3_mc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // with the result register empty, requests are always taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused with empty result register");

  // every accepted request has a result showing once it has passed the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("result missing two cycles after request");

  // no result straight out of reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind multicart_mmc3_bank_mapper_top mmc3_mc_checker u_chk (.*);

@@ tb/multicart_mmc3_bank_mapper_top_tb.sv @@
// Self-checking stream testbench for the multicart MMC3 bank mapper top level.
module multicart_mmc3_bank_mapper_top_tb;

  // Address decode constants of the CPU bus
  localparam logic [15:0] ADDR_MASK     = 16'hE001;
  localparam logic [15:0] ADDR_SELECT   = 16'h8000;
  localparam logic [15:0] ADDR_DATA     = 16'h8001;
  localparam logic [15:0] ADDR_OUTER_LO = 16'h6000;
  localparam logic [15:0] ADDR_MIRROR   = 16'h1FFE;  // don't-care bits of the E001 decode

  localparam int OUT_LATENCY  = 2;       // input register plus result register
  localparam int CYCLE_LIMIT  = 400000;  // watchdog: the run fails if it goes on past this limit
  localparam int PHASE_WRITES = 85;      // decoded random requests per ROM size setting
  localparam int NUM_PHASES   = 8;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [15:0] addr;
    logic [7:0]  data;
    bit          drain;  // hold back until every result so far has come out
  } cpu_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [15:0] cpu_address, [23:16] cpu_data
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // [23:0] prg_bank_slot0..3, [95:24] chr_bank_slot0..7

  multicart_mmc3_bank_mapper_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mapper shadow: ROM size, outer register, select and modes, slot stores
  // ---------------------------------------------------------------------------
  logic [5:0] rom_prg_last;
  logic [8:0] rom_chr_last;
  logic [5:0] outer_reg;
  logic [2:0] bank_sel;
  logic       prg_mode_q;
  logic       chr_mode_q;
  logic [7:0] prg_val [4];
  logic [8:0] chr_val [8];

  cpu_write_t             pending_writes [$];   // requests not yet accepted
  mmc3_mc_pkg::bank_out_t expected_banks [$];   // bank sets owed by the block, oldest first

  int cycle_cnt = 0;
  int err_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int ready_phase = 0;

  function automatic mmc3_mc_pkg::wr_kind_t decode_write(logic [15:0] a);
    if (a[15]) begin
      if ((a & ADDR_MASK) == ADDR_SELECT) return mmc3_mc_pkg::WR_SELECT;
      if ((a & ADDR_MASK) == ADDR_DATA)   return mmc3_mc_pkg::WR_DATA;
      return mmc3_mc_pkg::WR_NONE;
    end
    if (a >= ADDR_OUTER_LO) return mmc3_mc_pkg::WR_OUTER;
    return mmc3_mc_pkg::WR_NONE;
  endfunction

  // Update the shadow for one CPU write
  function automatic void apply_cpu_write(logic [15:0] a, logic [7:0] d);
    logic [7:0] even;
    logic [7:0] t8;
    logic [8:0] t9;
    logic [2:0] half;
    logic [2:0] other;
    int k;
    even = d & 8'hFE;
    half = chr_mode_q ? 3'd4 : 3'd0;
    other = half ^ 3'd4;
    case (decode_write(a))
      mmc3_mc_pkg::WR_OUTER: outer_reg = {d[1:0], 4'b0000};
      mmc3_mc_pkg::WR_SELECT: begin
        bank_sel = d[2:0];
        // CHR mode flip swaps the 2K and 1K halves
        if (d[7] != chr_mode_q) begin
          for (k = 0; k < 4; k++) begin
            t9 = chr_val[k];
            chr_val[k] = chr_val[k + 4];
            chr_val[k + 4] = t9;
          end
        end
        // PRG mode flip swaps slots 0 and 2, then pins the fixed one to last-1
        if (d[6] != prg_mode_q) begin
          t8 = prg_val[0];
          prg_val[0] = prg_val[2];
          prg_val[2] = t8;
          prg_val[d[6] ? 0 : 2] = {2'b00, rom_prg_last} - 8'd1;
        end
        prg_mode_q = d[6];
        chr_mode_q = d[7];
      end
      mmc3_mc_pkg::WR_DATA: begin
        case (bank_sel)
          mmc3_mc_pkg::SEL_CHR_2K_LO: begin
            chr_val[half] = {1'b0, even};
            chr_val[half | 3'd1] = {1'b0, even} + 9'd1;
          end
          mmc3_mc_pkg::SEL_CHR_2K_HI: begin
            chr_val[half | 3'd2] = {1'b0, even};
            chr_val[half | 3'd3] = {1'b0, even} + 9'd1;
          end
          mmc3_mc_pkg::SEL_CHR_1K_0: chr_val[other] = {1'b0, d};
          mmc3_mc_pkg::SEL_CHR_1K_1: chr_val[other | 3'd1] = {1'b0, d};
          mmc3_mc_pkg::SEL_CHR_1K_2: chr_val[other | 3'd2] = {1'b0, d};
          mmc3_mc_pkg::SEL_CHR_1K_3: chr_val[other | 3'd3] = {1'b0, d};
          mmc3_mc_pkg::SEL_PRG_SWAP: prg_val[prg_mode_q ? 2 : 0] = d;
          default:                   prg_val[1] = d;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Final bank numbers: outer register merged in, wrapped to the ROM size
  function automatic mmc3_mc_pkg::bank_out_t current_banks();
    mmc3_mc_pkg::bank_out_t b;
    logic [5:0] mask;
    logic [5:0] p;
    logic [8:0] c;
    int k;
    mask = outer_reg[5] ? mmc3_mc_pkg::PRG_MASK_SMALL : mmc3_mc_pkg::PRG_MASK_LARGE;
    for (k = 0; k < 4; k++) begin
      p = outer_reg | (prg_val[k][5:0] & mask);
      if (p > rom_prg_last) p &= rom_prg_last;
      b.prg_bank[k] = p;
    end
    for (k = 0; k < 8; k++) begin
      c = {outer_reg, 3'b000} | chr_val[k];
      if (c > rom_chr_last) c &= rom_chr_last;
      b.chr_bank[k] = c;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps, long gap-free runs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    bit send;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      // request taken at this edge: predict its banks and retire it
      if (in_tvalid) begin
        apply_cpu_write(in_tdata[15:0], in_tdata[23:16]);
        expected_banks.push_back(current_banks());
        void'(pending_writes.pop_front());
      end
      send = 1'b0;
      if (gap_left > 0)
        gap_left--;
      else if (pending_writes.size() > 0 &&
               !(pending_writes[0].drain && expected_banks.size() != 0))
        send = 1'b1;
      if (send) begin
        in_tdata <= {pending_writes[0].data, pending_writes[0].addr};
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(3, 0) == 0) begin
          burst_left = $urandom_range(80, 20);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(12, 1);
          gap_left = $urandom_range(6, 1);
        end
      end
      in_tvalid <= send;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    mmc3_mc_pkg::bank_out_t want;
    mmc3_mc_pkg::bank_out_t got;
    int k;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_banks.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with no request outstanding, expected none got %h",
                     $time, out_tdata);
        end else begin
          want = expected_banks.pop_front();
          for (k = 0; k < 4; k++) begin
            if (got.prg_bank[k] !== want.prg_bank[k]) begin
              err_count++;
              if (err_count <= MAX_REPORTS)
                $display("%0t: prg_bank_slot%0d expected %0d got %0d",
                         $time, k, want.prg_bank[k], got.prg_bank[k]);
            end
          end
          for (k = 0; k < 8; k++) begin
            if (got.chr_bank[k] !== want.chr_bank[k]) begin
              err_count++;
              if (err_count <= MAX_REPORTS)
                $display("%0t: chr_bank_slot%0d expected %0d got %0d",
                         $time, k, want.chr_bank[k], got.chr_bank[k]);
            end
          end
        end
      end
      // four stall styles in turn: none, random, periodic, rare long stalls
      ready_phase++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        case ((ready_phase >> 8) & 3)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(3, 0) != 0);
          2: out_tready <= ((ready_phase % 7) < 4);
          default: begin
            if ($urandom_range(15, 0) == 0) begin
              stall_left = $urandom_range(12, 2);
              out_tready <= 1'b0;
            end else begin
              out_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** multicart_mmc3_bank_mapper_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_write(logic [15:0] a, logic [7:0] d, bit drain = 1'b0);
    cpu_write_t w;
    w.addr = a;
    w.data = d;
    w.drain = drain;
    pending_writes.push_back(w);
  endtask

  // Mostly select/data pairs with random content, some outer writes, some noise
  task automatic queue_random_writes(int n);
    int counted;
    int r;
    logic [15:0] a;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(99, 0);
      if (r < 60) begin
        push_write(ADDR_SELECT | (16'($urandom) & ADDR_MIRROR), 8'($urandom),
                   counted >= n / 2 && counted < n / 2 + 2);
        push_write(ADDR_DATA | (16'($urandom) & ADDR_MIRROR), 8'($urandom));
        counted += 2;
      end else if (r < 72) begin
        push_write(ADDR_OUTER_LO + 16'($urandom_range(16'h1FFF, 0)), 8'($urandom));
        counted++;
      end else if (r < 80) begin
        push_write(ADDR_DATA | (16'($urandom) & ADDR_MIRROR), 8'($urandom));
        counted++;
      end else begin
        a = 16'($urandom);
        push_write(a, 8'($urandom));
        if (decode_write(a) != mmc3_mc_pkg::WR_NONE) counted++;
      end
    end
  endtask

  // Block idle: queue empty, nothing in flight, pipeline given time to settle
  task automatic wait_idle();
    while (pending_writes.size() != 0 || in_tvalid || expected_banks.size() != 0)
      @(posedge clk);
    repeat (2 * OUT_LATENCY + 4) @(posedge clk);
  endtask

  task automatic rom_size_write(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == mmc3_mc_pkg::REG_PRG_LAST) rom_prg_last = value[5:0];
    else rom_chr_last = value[8:0];
  endtask

  initial begin : stimulus
    int ph;
    int k;
    logic [31:0] prg_cfg;
    logic [31:0] chr_cfg;

    rom_prg_last = mmc3_mc_pkg::PRG_LAST_RST;
    rom_chr_last = mmc3_mc_pkg::CHR_LAST_RST;
    outer_reg    = mmc3_mc_pkg::OUTER_RST;
    bank_sel     = mmc3_mc_pkg::SEL_CHR_2K_LO;
    prg_mode_q   = 1'b0;
    chr_mode_q   = 1'b0;
    prg_val[0]   = mmc3_mc_pkg::PRG_SLOT0_RST;
    prg_val[1]   = mmc3_mc_pkg::PRG_SLOT1_RST;
    prg_val[2]   = mmc3_mc_pkg::PRG_SLOT2_RST;
    prg_val[3]   = mmc3_mc_pkg::PRG_SLOT3_RST;
    for (k = 0; k < 8; k++) chr_val[k] = 9'(k);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset banks, every select, both mode flips, mirrors, ignored writes
    push_write(ADDR_OUTER_LO, 8'h00);                       // outer cleared, bit 5 low
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_CHR_2K_LO});
    push_write(ADDR_DATA, 8'hFF);                           // odd value stored even-aligned
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_CHR_2K_HI});
    push_write(ADDR_DATA, 8'h00);
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_CHR_1K_0});
    push_write(16'h9FFF, 8'hFF);                            // data port through mirror
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_CHR_1K_1});
    push_write(ADDR_DATA, 8'h80);
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_CHR_1K_2});
    push_write(ADDR_DATA, 8'h55);
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_CHR_1K_3});
    push_write(ADDR_DATA, 8'hAA);
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_PRG_SWAP});
    push_write(ADDR_DATA, 8'h3F);
    push_write(ADDR_SELECT, {5'b00000, mmc3_mc_pkg::SEL_PRG_MID});
    push_write(ADDR_DATA, 8'hFF);
    push_write(ADDR_SELECT, {5'b11000, mmc3_mc_pkg::SEL_CHR_2K_LO});  // both modes flip
    push_write(ADDR_DATA, 8'h12);
    push_write(16'h9FFE, {5'b00000, mmc3_mc_pkg::SEL_PRG_SWAP});      // flip back, mirror
    push_write(16'h7FFF, 8'hFF);                            // outer bit 5 set, small PRG mask
    push_write(ADDR_DATA, 8'hC0);
    push_write(16'h5FFF, 8'hFF);                            // below outer window: ignored
    push_write(16'hA000, 8'h55);                            // fails E001 decode: ignored
    push_write(16'hFFFF, 8'hFF);
    push_write(16'h0000, 8'h00);
    queue_random_writes(PHASE_WRITES);
    wait_idle();

    // Further ROM sizes: smallest, largest, mid, then random ones
    for (ph = 1; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin prg_cfg = 32'd1;  chr_cfg = 32'd0;   end
        2: begin prg_cfg = 32'd63; chr_cfg = 32'd511; end
        3: begin prg_cfg = 32'd31; chr_cfg = 32'd255; end
        default: begin
          prg_cfg = $urandom_range(63, 1);
          chr_cfg = $urandom_range(511, 0);
        end
      endcase
      rom_size_write(mmc3_mc_pkg::REG_PRG_LAST, prg_cfg);
      rom_size_write(mmc3_mc_pkg::REG_CHR_LAST, chr_cfg);
      queue_random_writes(PHASE_WRITES);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("** multicart_mmc3_bank_mapper_top: PASSED **");
    end else begin
      $display("** multicart_mmc3_bank_mapper_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ multicart_mmc3_bank_mapper_top.f @@
src/mmc3_mc_pkg.sv
src/mmc3_mc_cfg.sv
src/mmc3_mc_state.sv
src/mmc3_mc_bank.sv
src/multicart_mmc3_bank_mapper_top.sv
src/mmc3_mc_checker.sv
tb/multicart_mmc3_bank_mapper_top_tb.sv
